// ----- rtl/i2c_master_byte_engine_defines.svh -----
// assertion helpers used by the i2c master sequencer rtl
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// clocked assertion, held off while reset is asserted
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

    // action codes of a request
    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4
    } action_t;

    // sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_ST_SCL_LO  = 5'd1,
        PH_ST_SDA_HI  = 5'd2,
        PH_ST_SCL_HI  = 5'd3,
        PH_ST_D1      = 5'd4,
        PH_ST_SDA_LO  = 5'd5,
        PH_ST_D2      = 5'd6,
        PH_FIN        = 5'd7,
        PH_SP_SCL_LO  = 5'd8,
        PH_SP_SDA_LO  = 5'd9,
        PH_SP_SCL_HI  = 5'd10,
        PH_SP_D1      = 5'd11,
        PH_SP_SDA_HI  = 5'd12,
        PH_SP_D2      = 5'd13,
        PH_WR_SCL_LO  = 5'd14,
        PH_WR_SDA     = 5'd15,
        PH_WR_D1      = 5'd16,
        PH_WR_SCL_HI  = 5'd17,
        PH_WR_D2      = 5'd18,
        PH_WR_SCL_LO2 = 5'd19,
        PH_AK_SDA_HI  = 5'd20,
        PH_AK_SCL_HI  = 5'd21,
        PH_AK_D       = 5'd22,
        PH_AK_POLL    = 5'd23,
        PH_RD_REL     = 5'd24,
        PH_RD_D0      = 5'd25,
        PH_RD_SCL_LO  = 5'd26,
        PH_RD_D1      = 5'd27,
        PH_RD_SCL_HI  = 5'd28,
        PH_RD_D2      = 5'd29
    } phase_t;

    // configuration register indexes
    typedef enum logic {
        REG_HALF_PERIOD = 1'b0,
        REG_ACK_TIMEOUT = 1'b1
    } reg_index_t;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd200;
    // shift value that sends a released data bit (nack) as the ninth bit
    localparam logic [7:0] NACK_SHIFT        = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    // one request
    typedef struct packed {
        logic       sda_level;
        logic       send_ack;
        logic [7:0] write_byte;
        logic [2:0] action;
    } req_t;

    // one result
    typedef struct packed {
        logic       acked;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_release;
    } res_t;

endpackage

// ----- rtl/i2cm_seq.sv -----
`include "i2c_master_byte_engine_defines.svh"

// bus sequencer: advances one step per accepted request
module i2cm_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [7:0]    cfg_data,
    input  logic          step_en,
    input  i2cm_pkg::req_t req,
    output i2cm_pkg::res_t res_next
);
    import i2cm_pkg::*;

    phase_t     phase_reg, phase_next, cur_phase;
    logic [7:0] delay_reg, delay_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [7:0] poll_reg, poll_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ack_flag_reg, ack_flag_next;
    logic [7:0] last_read_reg, last_read_next;
    logic [7:0] half_reg, tmo_reg;
    logic       done;

    logic [7:0] half_eff, tmo_eff, delay_inc, poll_inc, sample;
    logic [3:0] bit_inc;
    logic       delay_done;

    // zero in a register acts as one
    assign half_eff   = (half_reg == 8'd0) ? 8'd1 : half_reg;
    assign tmo_eff    = (tmo_reg == 8'd0) ? 8'd1 : tmo_reg;
    assign delay_inc  = delay_reg + 8'd1;
    assign delay_done = (delay_inc >= half_eff);
    assign poll_inc   = poll_reg + 8'd1;

    // next state: command launch, then one step of the running command
    always_comb begin
        phase_next      = phase_reg;
        delay_next      = delay_reg;
        bit_next        = bit_reg;
        shifter_next    = shifter_reg;
        poll_next       = poll_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_flag_next   = ack_flag_reg;
        last_read_next  = last_read_reg;
        done            = 1'b0;
        cur_phase       = phase_reg;
        bit_inc         = 4'd0;
        sample          = 8'd0;

        // launch only from idle; the action of a request while busy is ignored
        if (phase_reg == PH_IDLE) begin
            case (action_t'(req.action))
                ACT_START: cur_phase = PH_ST_SCL_LO;
                ACT_STOP:  cur_phase = PH_SP_SCL_LO;
                ACT_WRITE: begin
                    shifter_next = req.write_byte;
                    bit_next     = 4'd0;
                    cur_phase    = PH_WR_SCL_LO;
                end
                ACT_READ: begin
                    shifter_next    = 8'd0;
                    bit_next        = 4'd0;
                    ack_choice_next = req.send_ack;
                    cur_phase       = PH_RD_REL;
                end
                default: ;
            endcase
        end

        unique case (cur_phase)
            PH_IDLE: ;
            PH_ST_SCL_LO: begin scl_next = 1'b0; phase_next = PH_ST_SDA_HI; delay_next = '0; end
            PH_ST_SDA_HI: begin sda_next = 1'b1; phase_next = PH_ST_SCL_HI; delay_next = '0; end
            PH_ST_SCL_HI: begin scl_next = 1'b1; phase_next = PH_ST_D1; delay_next = '0; end
            PH_ST_D1, PH_ST_D2, PH_SP_D1, PH_WR_D1, PH_WR_D2, PH_AK_D, PH_RD_D0,
            PH_RD_D1: begin
                if (delay_done) begin
                    delay_next = '0;
                    case (cur_phase)
                        PH_ST_D1: phase_next = PH_ST_SDA_LO;
                        PH_ST_D2: phase_next = PH_FIN;
                        PH_SP_D1: phase_next = PH_SP_SDA_HI;
                        PH_WR_D1: phase_next = PH_WR_SCL_HI;
                        PH_WR_D2: phase_next = PH_WR_SCL_LO2;
                        PH_AK_D: begin
                            poll_next  = 8'd0;
                            phase_next = PH_AK_POLL;
                        end
                        PH_RD_D0: phase_next = PH_RD_SCL_LO;
                        default:  phase_next = PH_RD_SCL_HI;
                    endcase
                end else begin
                    delay_next = delay_inc;
                end
            end
            PH_ST_SDA_LO: begin sda_next = 1'b0; phase_next = PH_ST_D2; delay_next = '0; end
            PH_FIN: begin
                scl_next   = 1'b0;
                phase_next = PH_IDLE;
                delay_next = '0;
                done       = 1'b1;
            end
            PH_SP_SCL_LO: begin scl_next = 1'b0; phase_next = PH_SP_SDA_LO; delay_next = '0; end
            PH_SP_SDA_LO: begin sda_next = 1'b0; phase_next = PH_SP_SCL_HI; delay_next = '0; end
            PH_SP_SCL_HI: begin scl_next = 1'b1; phase_next = PH_SP_D1; delay_next = '0; end
            PH_SP_SDA_HI: begin sda_next = 1'b1; phase_next = PH_SP_D2; delay_next = '0; end
            PH_SP_D2: begin
                if (delay_done) begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    done       = 1'b1;
                end else begin
                    delay_next = delay_inc;
                end
            end
            PH_WR_SCL_LO: begin scl_next = 1'b0; phase_next = PH_WR_SDA; delay_next = '0; end
            PH_WR_SDA: begin
                sda_next   = shifter_next[7];
                phase_next = PH_WR_D1;
                delay_next = '0;
            end
            PH_WR_SCL_HI: begin scl_next = 1'b1; phase_next = PH_WR_D2; delay_next = '0; end
            PH_WR_SCL_LO2: begin
                scl_next     = 1'b0;
                shifter_next = {shifter_next[6:0], 1'b0};
                bit_inc      = bit_next + 4'd1;
                bit_next     = bit_inc;
                delay_next   = '0;
                // eight data bits go to the ack check; the ninth bit of a read ends it
                if (bit_inc == BITS_PER_BYTE) begin
                    phase_next = PH_AK_SDA_HI;
                end else if (bit_inc > BITS_PER_BYTE) begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end else begin
                    phase_next = PH_WR_SCL_LO;
                end
            end
            PH_AK_SDA_HI: begin sda_next = 1'b1; phase_next = PH_AK_SCL_HI; delay_next = '0; end
            PH_AK_SCL_HI: begin
                scl_next   = 1'b1;
                poll_next  = 8'd0;
                phase_next = PH_AK_D;
                delay_next = '0;
            end
            PH_AK_POLL: begin
                // low data line is an ack, otherwise count toward the timeout
                if (!req.sda_level) begin
                    ack_flag_next = 1'b1;
                    phase_next    = PH_FIN;
                    delay_next    = '0;
                end else begin
                    poll_next = poll_inc;
                    if (poll_inc >= tmo_eff) begin
                        ack_flag_next = 1'b0;
                        phase_next    = PH_FIN;
                        delay_next    = '0;
                    end
                end
            end
            PH_RD_REL: begin sda_next = 1'b1; phase_next = PH_RD_D0; delay_next = '0; end
            PH_RD_SCL_LO: begin scl_next = 1'b0; phase_next = PH_RD_D1; delay_next = '0; end
            PH_RD_SCL_HI: begin scl_next = 1'b1; phase_next = PH_RD_D2; delay_next = '0; end
            PH_RD_D2: begin
                if (delay_done) begin
                    sample     = {shifter_next[6:0], req.sda_level};
                    bit_inc    = bit_next + 4'd1;
                    delay_next = '0;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        // byte complete: send ack or nack as a ninth written bit
                        last_read_next = sample;
                        shifter_next   = ack_choice_next ? 8'd0 : NACK_SHIFT;
                        bit_next       = BITS_PER_BYTE;
                        phase_next     = PH_WR_SCL_LO;
                    end else begin
                        shifter_next = sample;
                        bit_next     = bit_inc;
                        phase_next   = PH_RD_SCL_LO;
                    end
                end else begin
                    delay_next = delay_inc;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                delay_next = '0;
            end
        endcase
    end

    // result of this step
    always_comb begin
        res_next.scl_release = scl_next;
        res_next.sda_release = sda_next;
        res_next.busy_res    = (phase_next != PH_IDLE);
        res_next.done_res    = done;
        res_next.read_byte   = last_read_next;
        res_next.acked       = ack_flag_next;
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            delay_reg      <= '0;
            bit_reg        <= '0;
            shifter_reg    <= '0;
            poll_reg       <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_flag_reg   <= 1'b0;
            last_read_reg  <= '0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            delay_reg      <= delay_next;
            bit_reg        <= bit_next;
            shifter_reg    <= shifter_next;
            poll_reg       <= poll_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_flag_reg   <= ack_flag_next;
            last_read_reg  <= last_read_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= HALF_PERIOD_RESET;
            tmo_reg  <= ACK_TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_HALF_PERIOD: half_reg <= cfg_data;
                default:         tmo_reg  <= cfg_data;
            endcase
        end
    end

    `I2CM_ASSERT(a_idle_delay_clear, (phase_reg == PH_IDLE) |-> (delay_reg == 8'd0), "delay count not clear in idle")
    `I2CM_ASSERT(a_bit_count_range, bit_reg <= (BITS_PER_BYTE + 4'd1), "bit count out of range")
    `I2CM_ASSERT(a_done_to_idle, (step_en && done) |=> (phase_reg == PH_IDLE), "finished command left sequencer busy")
    `I2CM_ASSERT(a_delay_bound, (phase_reg != PH_IDLE) |-> (delay_reg < half_eff), "delay count ran past half period")

endmodule

// ----- rtl/i2cm_out.sv -----
// result register between the sequencer and the master side
module i2cm_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  i2cm_pkg::res_t res_next,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic           slot_free,
    output i2cm_pkg::res_t res
);
    import i2cm_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    // a held result frees its slot on the edge it is taken
    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign res      = res_reg;

endmodule

// ----- rtl/i2c_master_byte_engine.sv -----
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------------
// s_       | in        | s_tvalid/s_tready  | request: action, byte, ack choice, sda
// m_       | out       | m_tvalid/m_tready  | result: line drives, busy, done, data
// cfg_     | in        | cfg_we             | half period, ack timeout
//
// one request per cycle while s_tready is high; each request is one bus tick
// and yields one result, produced by one pass through the sequencer step logic
// into the result register, so it is on m_tdata in the cycle after it is taken
// s_tready drops only while the result register is full and m_tready is low
// aresetn is synchronous and active low; both lines come out of reset released
module i2c_master_byte_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] action, [10:3] write_byte, [11] send_ack, [12] sda_level, [15:13] zero
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    // [11:4] read_byte, [12] acked, [15:13] zero
    output logic [15:0] m_tdata
);
    import i2cm_pkg::*;

    req_t req;
    res_t res_next, res;
    logic slot_free, accept;

    assign req      = req_t'(s_tdata[12:0]);
    assign s_tready = slot_free;
    assign accept   = s_tvalid && slot_free;

    // step logic and state
    i2cm_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (accept),
        .req       (req),
        .res_next  (res_next)
    );

    // result register
    i2cm_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .res_next  (res_next),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .slot_free (slot_free),
        .res       (res)
    );

    assign m_tdata = {3'b000, res};

endmodule

// ----- verif/i2cm_tick_checker.sv -----
`timescale 1ns / 100ps

module i2cm_tick_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [2:0] action, [10:3] write_byte, [11] send_ack, [12] sda_level, [15:13] zero
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    // [11:4] read_byte, [12] acked, [15:13] zero
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output logic        model_busy
);
    import i2cm_pkg::*;

    // shadow copy of the sequencer
    phase_t     seq_phase;
    logic [7:0] delay_ticks;
    logic [3:0] bits_done;
    logic [7:0] shifter;
    logic [7:0] polls;
    logic       ack_sel;
    logic       scl_rel;
    logic       sda_rel;
    logic       acked_flag;
    logic [7:0] read_hold;
    logic [7:0] half_cfg;
    logic [7:0] timeout_cfg;

    // predicted line states, oldest first
    res_t bus_tick_q[$];

    task automatic goto_phase(input phase_t p);
        seq_phase   = p;
        delay_ticks = 8'd0;
    endtask

    // one tick of a bus delay, zero half period acts as one
    function automatic logic delay_elapsed();
        delay_ticks = delay_ticks + 8'd1;
        return delay_ticks >= ((half_cfg == 8'd0) ? 8'd1 : half_cfg);
    endfunction

    // one step of a running command
    task automatic step_sequencer(input logic sda_in, output logic fin);
        logic [7:0] tmo_eff;
        fin     = 1'b0;
        tmo_eff = (timeout_cfg == 8'd0) ? 8'd1 : timeout_cfg;
        case (seq_phase)
            // start condition
            PH_ST_SCL_LO: begin scl_rel = 1'b0; goto_phase(PH_ST_SDA_HI); end
            PH_ST_SDA_HI: begin sda_rel = 1'b1; goto_phase(PH_ST_SCL_HI); end
            PH_ST_SCL_HI: begin scl_rel = 1'b1; goto_phase(PH_ST_D1); end
            PH_ST_D1:     if (delay_elapsed()) goto_phase(PH_ST_SDA_LO);
            PH_ST_SDA_LO: begin sda_rel = 1'b0; goto_phase(PH_ST_D2); end
            PH_ST_D2:     if (delay_elapsed()) goto_phase(PH_FIN);
            PH_FIN: begin
                scl_rel = 1'b0;
                goto_phase(PH_IDLE);
                fin = 1'b1;
            end
            // stop condition
            PH_SP_SCL_LO: begin scl_rel = 1'b0; goto_phase(PH_SP_SDA_LO); end
            PH_SP_SDA_LO: begin sda_rel = 1'b0; goto_phase(PH_SP_SCL_HI); end
            PH_SP_SCL_HI: begin scl_rel = 1'b1; goto_phase(PH_SP_D1); end
            PH_SP_D1:     if (delay_elapsed()) goto_phase(PH_SP_SDA_HI);
            PH_SP_SDA_HI: begin sda_rel = 1'b1; goto_phase(PH_SP_D2); end
            PH_SP_D2: begin
                if (delay_elapsed()) begin
                    goto_phase(PH_IDLE);
                    fin = 1'b1;
                end
            end
            // one written bit, msb first
            PH_WR_SCL_LO: begin scl_rel = 1'b0; goto_phase(PH_WR_SDA); end
            PH_WR_SDA:    begin sda_rel = shifter[7]; goto_phase(PH_WR_D1); end
            PH_WR_D1:     if (delay_elapsed()) goto_phase(PH_WR_SCL_HI);
            PH_WR_SCL_HI: begin scl_rel = 1'b1; goto_phase(PH_WR_D2); end
            PH_WR_D2:     if (delay_elapsed()) goto_phase(PH_WR_SCL_LO2);
            PH_WR_SCL_LO2: begin
                scl_rel   = 1'b0;
                shifter   = {shifter[6:0], 1'b0};
                bits_done = bits_done + 4'd1;
                if (bits_done == BITS_PER_BYTE) begin
                    goto_phase(PH_AK_SDA_HI);
                end else if (bits_done > BITS_PER_BYTE) begin
                    // ack bit of a read has gone out
                    goto_phase(PH_IDLE);
                    fin = 1'b1;
                end else begin
                    goto_phase(PH_WR_SCL_LO);
                end
            end
            // acknowledge check after a written byte
            PH_AK_SDA_HI: begin sda_rel = 1'b1; goto_phase(PH_AK_SCL_HI); end
            PH_AK_SCL_HI: begin
                scl_rel = 1'b1;
                polls   = 8'd0;
                goto_phase(PH_AK_D);
            end
            PH_AK_D: begin
                if (delay_elapsed()) begin
                    polls = 8'd0;
                    goto_phase(PH_AK_POLL);
                end
            end
            PH_AK_POLL: begin
                if (!sda_in) begin
                    acked_flag = 1'b1;
                    goto_phase(PH_FIN);
                end else begin
                    polls = polls + 8'd1;
                    if (polls >= tmo_eff) begin
                        acked_flag = 1'b0;
                        goto_phase(PH_FIN);
                    end
                end
            end
            // read byte, sampled at the end of the high half
            PH_RD_REL:    begin sda_rel = 1'b1; goto_phase(PH_RD_D0); end
            PH_RD_D0:     if (delay_elapsed()) goto_phase(PH_RD_SCL_LO);
            PH_RD_SCL_LO: begin scl_rel = 1'b0; goto_phase(PH_RD_D1); end
            PH_RD_D1:     if (delay_elapsed()) goto_phase(PH_RD_SCL_HI);
            PH_RD_SCL_HI: begin scl_rel = 1'b1; goto_phase(PH_RD_D2); end
            PH_RD_D2: begin
                if (delay_elapsed()) begin
                    shifter   = {shifter[6:0], sda_in};
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= BITS_PER_BYTE) begin
                        // ack or nack goes out as a ninth written bit
                        read_hold = shifter;
                        shifter   = ack_sel ? 8'h00 : NACK_SHIFT;
                        bits_done = BITS_PER_BYTE;
                        goto_phase(PH_WR_SCL_LO);
                    end else begin
                        goto_phase(PH_RD_SCL_LO);
                    end
                end
            end
            default: goto_phase(PH_IDLE);
        endcase
    endtask

    // one request in, one predicted line state out
    task automatic predict_tick(input req_t rq, output res_t rs);
        logic fin;
        fin = 1'b0;
        if (seq_phase == PH_IDLE) begin
            case (rq.action)
                ACT_START: goto_phase(PH_ST_SCL_LO);
                ACT_STOP:  goto_phase(PH_SP_SCL_LO);
                ACT_WRITE: begin
                    shifter   = rq.write_byte;
                    bits_done = 4'd0;
                    goto_phase(PH_WR_SCL_LO);
                end
                ACT_READ: begin
                    shifter   = 8'h00;
                    bits_done = 4'd0;
                    ack_sel   = rq.send_ack;
                    goto_phase(PH_RD_REL);
                end
                default: ;
            endcase
        end
        if (seq_phase != PH_IDLE) step_sequencer(rq.sda_level, fin);
        rs.scl_release = scl_rel;
        rs.sda_release = sda_rel;
        rs.busy_res    = (seq_phase != PH_IDLE);
        rs.done_res    = fin;
        rs.read_byte   = read_hold;
        rs.acked       = acked_flag;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t checker: %s expected %0h actual %0h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    // results are compared before the request of the same edge is predicted
    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        req_t rq;
        if (!aresetn) begin
            seq_phase   = PH_IDLE;
            delay_ticks = 8'd0;
            bits_done   = 4'd0;
            shifter     = 8'd0;
            polls       = 8'd0;
            ack_sel     = 1'b0;
            scl_rel     = 1'b1;
            sda_rel     = 1'b1;
            acked_flag  = 1'b0;
            read_hold   = 8'd0;
            half_cfg    = HALF_PERIOD_RESET;
            timeout_cfg = ACK_TIMEOUT_RESET;
            fail_count  = 0;
            bus_tick_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[12:0]);
                if (bus_tick_q.size() == 0) begin
                    $display("%0t checker: result with nothing predicted, actual %0h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = bus_tick_q.pop_front();
                    check_field("scl_release", 8'(want.scl_release), 8'(got.scl_release));
                    check_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
                    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("acked", 8'(want.acked), 8'(got.acked));
                    check_field("tdata pad", 8'd0, 8'(m_tdata[15:13]));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_HALF_PERIOD: half_cfg    = cfg_data;
                    REG_ACK_TIMEOUT: timeout_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                rq = req_t'(s_tdata[12:0]);
                predict_tick(rq, want);
                bus_tick_q.push_back(want);
            end
        end
        pending    = bus_tick_q.size();
        model_busy = (seq_phase != PH_IDLE);
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import i2cm_pkg::*;

    localparam int         QUIET_LIMIT  = 4000;
    localparam logic [2:0] ACT_CODE_MAX = 3'b111;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    // [2:0] action, [10:3] write_byte, [11] send_ack, [12] sda_level, [15:13] zero
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    // [11:4] read_byte, [12] acked, [15:13] zero
    logic [15:0] m_tdata;

    int   fail_count;
    int   pending;
    logic model_busy;

    int burst_left;
    bit gaps_on;
    int stall_ctr = 0;
    int stall_pct = 0;

    i2c_master_byte_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    i2cm_tick_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .model_busy (model_busy)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver stalls with a rate that is redrawn whenever a random countdown runs out
    always @(negedge aclk) begin
        if (stall_ctr == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pct <= 0;
                1:       stall_pct <= 20;
                2:       stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
            stall_ctr <= $urandom_range(50, 300);
        end else begin
            stall_ctr <= stall_ctr - 1;
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
    end

    // one request, sent in bursts with random gaps between them while gaps_on is set
    task automatic send_req(input req_t rq);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, rq};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic issue(input logic [2:0] act, input logic [7:0] wbyte,
                         input logic sack, input logic sda);
        req_t rq;
        rq.action     = act;
        rq.write_byte = wbyte;
        rq.send_ack   = sack;
        rq.sda_level  = sda;
        send_req(rq);
    endtask

    // tick-only requests until the running command has finished
    task automatic finish_command(input int sda_hi_pct);
        while (model_busy)
            issue(ACT_TICK, 8'($urandom), 1'($urandom),
                  $urandom_range(0, 99) < sda_hi_pct);
    endtask

    task automatic pause_until_drained(input bit need_idle);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0 || (need_idle && model_busy)) @(negedge aclk);
    endtask

    // both registers, only with the sequencer idle
    task automatic program_regs(input logic [7:0] half, input logic [7:0] tmo);
        pause_until_drained(1'b1);
        repeat (2) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HALF_PERIOD;
        cfg_data  <= half;
        @(negedge aclk);
        cfg_index <= REG_ACK_TIMEOUT;
        cfg_data  <= tmo;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // random commands, mostly real ones, under one register setting
    task automatic random_phase(input logic [7:0] half, input logic [7:0] tmo,
                                input int count, input int sda_hi_pct,
                                input bit use_gaps, input bit mid_pause);
        int         pick;
        logic [2:0] act;
        program_regs(half, tmo);
        gaps_on = use_gaps;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                act = 3'($urandom_range(ACT_START, ACT_READ));
            else if (pick < 90)
                act = ACT_TICK;
            else
                act = 3'($urandom_range(ACT_READ + 1, ACT_CODE_MAX));
            issue(act, 8'($urandom), 1'($urandom), $urandom_range(0, 99) < sda_hi_pct);
            if (mid_pause && i == count / 2) pause_until_drained(1'b0);
        end
        finish_command(sda_hi_pct);
        gaps_on = 1'b1;
    endtask

    // stimulus and verdict
    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_HALF_PERIOD;
        cfg_data   = 8'd0;
        s_tvalid   = 1'b0;
        s_tdata    = 16'd0;
        burst_left = 0;
        gaps_on    = 1'b1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: short timing so every command completes quickly
        program_regs(8'd1, 8'd4);
        issue(ACT_TICK, 8'h00, 1'b0, 1'b0);
        for (int c = ACT_READ + 1; c <= ACT_CODE_MAX; c++)
            issue(3'(c), 8'hFF, 1'b1, 1'b1);
        issue(ACT_START, 8'hFF, 1'b1, 1'b1);
        finish_command(100);
        // acked write, with a start ignored while busy
        issue(ACT_WRITE, 8'hFF, 1'b1, 1'b0);
        issue(ACT_START, 8'h00, 1'b0, 1'b0);
        finish_command(0);
        // write that runs into the ack timeout
        issue(ACT_WRITE, 8'h00, 1'b0, 1'b1);
        finish_command(100);
        // reads of all ones with ack and all zeros with nack
        issue(ACT_READ, 8'hFF, 1'b1, 1'b1);
        finish_command(100);
        issue(ACT_READ, 8'h00, 1'b0, 1'b0);
        finish_command(0);
        // stop, with a read ignored while busy
        issue(ACT_STOP, 8'hA5, 1'b1, 1'b1);
        issue(ACT_READ, 8'h5A, 1'b0, 1'b0);
        finish_command(50);

        // random phases over several settings
        random_phase(8'd1, 8'd1, 150, 50, 1'b1, 1'b1);
        random_phase(8'd2, 8'd3, 120, 80, 1'b0, 1'b0);
        random_phase(8'd0, 8'd0, 100, 60, 1'b1, 1'b0);
        random_phase(8'd1, 8'd255, 120, 100, 1'b1, 1'b0);
        random_phase(8'd6, 8'd9, 100, 50, 1'b1, 1'b0);
        random_phase(HALF_PERIOD_RESET, ACK_TIMEOUT_RESET, 100, 95, 1'b1, 1'b0);

        pause_until_drained(1'b0);
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog on cycles with no handshake on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge aresetn);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_seq.sv
rtl/i2cm_out.sv
rtl/i2c_master_byte_engine.sv
verif/i2cm_tick_checker.sv
verif/testbench.sv
